// ===== sv/assert_macros.svh =====
// Assertion macros used inside the top-level file of the fully connected layer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock edge, switched off while reset is held.
`define FCLF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FCLF_ASSERT_NEXT(label, ante, cons, msg) \
  `FCLF_ASSERT(label, (ante) |=> (cons), msg)

// Consequent checked in the same cycle as the antecedent.
`define FCLF_ASSERT_SAME(label, ante, cons, msg) \
  `FCLF_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== sv/fclf_pkg.sv =====
// Shared types and constants of the fully connected layer engine.
`timescale 1ns / 1ps
`default_nettype none

package fclf_pkg;

  localparam int ACC_W      = 48;
  localparam int MODE_W     = 2;
  localparam int INDEX_W    = 8;
  localparam int SAMPLE_W   = 16;
  localparam int OUT_ROW_W  = 6;
  localparam int OUT_COL_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int IN_CNT_W   = 9;
  localparam int OUT_CNT_W  = 7;

  localparam logic [MODE_W-1:0] MODE_LOAD_WEIGHT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_INPUT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RUN         = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 1'b1;

  localparam logic [IN_CNT_W-1:0]  IN_CNT_RESET  = 9'd256;
  localparam logic [OUT_CNT_W-1:0] OUT_CNT_RESET = 7'd64;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_weight;
    logic wr_input;
    logic start;
    logic issue;
    logic first;
    logic last_m;
    logic push;
    logic last_row;
  } fclf_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic acc_done;
    logic out_free;
  } fclf_status_t;

endpackage

`default_nettype wire

// ===== sv/fclf_if.sv =====
// Request channel interfaces of the fully connected layer engine.
`timescale 1ns / 1ps
`default_nettype none

interface fclf_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [fclf_pkg::MODE_W-1:0]     mode;
  logic        [fclf_pkg::INDEX_W-1:0]    row_index;
  logic        [fclf_pkg::INDEX_W-1:0]    col_index;
  logic signed [fclf_pkg::SAMPLE_W-1:0]   sample_value;

  modport source (output valid, mode, row_index, col_index, sample_value, input ready);
  modport sink   (input valid, mode, row_index, col_index, sample_value, output ready);
endinterface

interface fclf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic        [fclf_pkg::OUT_ROW_W-1:0]  out_row;
  logic        [fclf_pkg::OUT_COL_W-1:0]  out_col;
  logic signed [fclf_pkg::ACC_W-1:0]      dot_value;
  logic                                   last;

  modport source (output valid, out_row, out_col, dot_value, last, input ready);
  modport sink   (input valid, out_row, out_col, dot_value, last, output ready);
endinterface

`default_nettype wire

// ===== sv/fclf_ctrl.sv =====
// Controller: configuration registers, request decode and the row/element sequencer.
`timescale 1ns / 1ps
`default_nettype none

module fclf_ctrl #(
  parameter int IN_MAX   = 256,
  parameter int OUT_MAX  = 64,
  parameter int COLS_MAX = 4,
  parameter int M_W      = 8,
  parameter int R_W      = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fclf_pkg::MODE_W-1:0]         in_mode,
  input  logic [fclf_pkg::INDEX_W-1:0]        in_row,
  input  logic [fclf_pkg::INDEX_W-1:0]        in_col,
  input  logic                                cfg_we,
  input  logic [fclf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fclf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output fclf_pkg::fclf_cmd_t                 cmd,
  output logic [R_W-1:0]                      row,
  output logic [M_W-1:0]                      m_idx,
  input  fclf_pkg::fclf_status_t              status
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [R_W-1:0]                   row_r, row_nxt;
  logic [R_W-1:0]                   row_last_r, row_last_nxt;
  logic [M_W-1:0]                   m_r, m_nxt;
  logic [M_W-1:0]                   m_last_r, m_last_nxt;
  logic [fclf_pkg::IN_CNT_W-1:0]    input_count_r;
  logic [fclf_pkg::OUT_CNT_W-1:0]   output_count_r;
  logic                             accept;
  int                               n_in;
  int                               n_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_count_r  <= fclf_pkg::IN_CNT_RESET;
      output_count_r <= fclf_pkg::OUT_CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fclf_pkg::CFG_INPUT_COUNT:  input_count_r  <= cfg_wdata;
        fclf_pkg::CFG_OUTPUT_COUNT: output_count_r <= cfg_wdata[fclf_pkg::OUT_CNT_W-1:0];
      endcase
    end
  end

  // Counts are clamped to the sizes the stores can hold.
  always_comb begin
    n_in  = int'(input_count_r);
    n_out = int'(output_count_r);
    if (n_in < 1) n_in = 1;
    if (n_in > IN_MAX) n_in = IN_MAX;
    if (n_out < 1) n_out = 1;
    if (n_out > OUT_MAX) n_out = OUT_MAX;
  end

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign row      = row_r;
  assign m_idx    = m_r;

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    row_last_nxt = row_last_r;
    m_nxt        = m_r;
    m_last_nxt   = m_last_r;
    cmd          = '0;
    cmd.first    = (m_r == '0);
    cmd.last_m   = (m_r == m_last_r);
    cmd.last_row = (row_r == row_last_r);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            fclf_pkg::MODE_LOAD_WEIGHT: begin
              cmd.wr_weight = (int'(in_row) < OUT_MAX) && (int'(in_col) < IN_MAX);
            end
            fclf_pkg::MODE_LOAD_INPUT: begin
              cmd.wr_input = (int'(in_row) < IN_MAX) && (int'(in_col) < COLS_MAX);
            end
            fclf_pkg::MODE_RUN: begin
              if (int'(in_col) < COLS_MAX) begin
                cmd.start    = 1'b1;
                row_nxt      = '0;
                m_nxt        = '0;
                m_last_nxt   = M_W'(n_in - 1);
                row_last_nxt = R_W'(n_out - 1);
                state_nxt    = ST_ISSUE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (m_r == m_last_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          m_nxt = m_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (status.acc_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (status.out_free) begin
          cmd.push = 1'b1;
          if (row_r == row_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            row_nxt   = row_r + 1'b1;
            m_nxt     = '0;
            state_nxt = ST_ISSUE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      row_r      <= '0;
      row_last_r <= '0;
      m_r        <= '0;
      m_last_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      row_last_r <= row_last_nxt;
      m_r        <= m_nxt;
      m_last_r   <= m_last_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fclf_dp.sv =====
// Datapath: weight and input stores, multiply-accumulate pipeline and result register.
`timescale 1ns / 1ps
`default_nettype none

module fclf_dp #(
  parameter int IN_MAX     = 256,
  parameter int OUT_MAX    = 64,
  parameter int COLS_MAX   = 4,
  parameter int VALUE_BITS = 16,
  parameter int M_W        = 8,
  parameter int R_W        = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fclf_pkg::fclf_cmd_t                   cmd,
  output fclf_pkg::fclf_status_t                status,
  input  logic [R_W-1:0]                        row,
  input  logic [M_W-1:0]                        m_idx,
  input  logic [fclf_pkg::INDEX_W-1:0]          in_row,
  input  logic [fclf_pkg::INDEX_W-1:0]          in_col,
  input  logic signed [fclf_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [fclf_pkg::OUT_ROW_W-1:0]        out_row,
  output logic [fclf_pkg::OUT_COL_W-1:0]        out_col,
  output logic signed [fclf_pkg::ACC_W-1:0]     out_dot,
  output logic                                  out_last
);

  localparam int W_DEPTH = OUT_MAX * IN_MAX;
  localparam int X_DEPTH = IN_MAX * COLS_MAX;
  localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int XA_W    = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
  localparam int C_W     = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int PROD_W  = 2 * VALUE_BITS;
  localparam int SUM_W   = ((PROD_W > fclf_pkg::ACC_W) ? PROD_W : fclf_pkg::ACC_W) + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(fclf_pkg::ACC_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(fclf_pkg::ACC_MIN);

  logic signed [VALUE_BITS-1:0]      weight_mem [W_DEPTH];
  logic signed [VALUE_BITS-1:0]      input_mem  [X_DEPTH];

  logic [C_W-1:0]                    col_r;
  logic [WA_W-1:0]                   w_waddr, w_raddr;
  logic [XA_W-1:0]                   x_waddr, x_raddr;
  logic signed [VALUE_BITS-1:0]      wdata;
  logic signed [VALUE_BITS-1:0]      w_rd_r, x_rd_r;
  logic                              s1_v_r, s1_first_r, s1_last_r;
  logic                              s2_v_r, s2_first_r, s2_last_r;
  logic signed [PROD_W-1:0]          prod_r;
  logic signed [fclf_pkg::ACC_W-1:0] acc_r;
  logic                              done_r;
  logic signed [SUM_W-1:0]           acc_in;
  logic signed [SUM_W-1:0]           sum;
  logic signed [fclf_pkg::ACC_W-1:0] sat;
  logic                              out_valid_r, out_valid_nxt;
  logic [fclf_pkg::OUT_ROW_W-1:0]    out_row_r;
  logic [fclf_pkg::OUT_COL_W-1:0]    out_col_r;
  logic signed [fclf_pkg::ACC_W-1:0] out_dot_r;
  logic                              out_last_r;

  // A loaded sample is sign extended or wrapped to the stored width.
  assign wdata   = VALUE_BITS'(in_sample);
  assign w_waddr = WA_W'(int'(in_row) * IN_MAX + int'(in_col));
  assign x_waddr = XA_W'(int'(in_row) * COLS_MAX + int'(in_col));
  assign w_raddr = WA_W'(int'(row) * IN_MAX + int'(m_idx));
  assign x_raddr = XA_W'(int'(m_idx) * COLS_MAX + int'(col_r));

  always_ff @(posedge clk) begin
    if (cmd.wr_weight) begin
      weight_mem[w_waddr] <= wdata;
    end
    if (cmd.issue) begin
      w_rd_r <= weight_mem[w_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_input) begin
      input_mem[x_waddr] <= wdata;
    end
    if (cmd.issue) begin
      x_rd_r <= input_mem[x_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      col_r <= C_W'(in_col);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      done_r <= s2_v_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= cmd.first;
    s1_last_r  <= cmd.last_m;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    prod_r     <= w_rd_r * x_rd_r;
  end

  // The running sum restarts on the first element of a row and saturates every step.
  always_comb begin
    acc_in = s2_first_r ? SUM_W'(0) : SUM_W'(acc_r);
    sum    = acc_in + SUM_W'(prod_r);
    if (sum > SAT_HI) begin
      sat = fclf_pkg::ACC_MAX;
    end else if (sum < SAT_LO) begin
      sat = fclf_pkg::ACC_MIN;
    end else begin
      sat = fclf_pkg::ACC_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      acc_r <= sat;
    end
  end

  assign status.acc_done = done_r;
  assign status.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_row_r  <= fclf_pkg::OUT_ROW_W'(row);
      out_col_r  <= fclf_pkg::OUT_COL_W'(col_r);
      out_dot_r  <= acc_r;
      out_last_r <= cmd.last_row;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_dot   = out_dot_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== sv/fully_connected_layer_forward.sv =====
// Fully connected layer forward pass: a weight-by-activation matrix multiply engine.
// Usage:
//   in_ch carries requests with valid/ready. Mode 0 stores one Q4.12 weight
//   (row_index = output row, col_index = input index); mode 1 stores one
//   activation (row_index = input element, col_index = column); mode 2 runs
//   the column in col_index. Loads are written as they are accepted; out-of-range
//   loads, runs of an unknown column and mode 3 are dropped without a result.
//   A run returns output_count results (clamped to 1..64) on out_ch, one per
//   output row, in row order, with last set on the final row. One
//   multiply-accumulate unit reads one weight and one activation per cycle
//   from the single read port of each store; the last pair then passes through
//   read, multiply, accumulate and hand-off. in_ch.ready is low while a run is
//   in progress; loads are taken while the last result still waits in the
//   output register. If out_ch stalls, the finished row is held and the next
//   row waits. cfg_we writes input_count (index 0) or output_count (index 1);
//   the user writes them only while idle; the block itself does not enforce it.
//   Synchronous reset sets the counts to 256 and 64 and clears all handshakes;
//   store contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fully_connected_layer_forward #(
  parameter int IN_MAX     = 256,
  parameter int OUT_MAX    = 64,
  parameter int COLS_MAX   = 4,
  parameter int VALUE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  fclf_in_if.sink                          in_ch,
  fclf_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [fclf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fclf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int M_W = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int R_W = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;

  fclf_pkg::fclf_cmd_t    cmd;
  fclf_pkg::fclf_status_t status;
  logic [R_W-1:0]         row;
  logic [M_W-1:0]         m_idx;

  fclf_ctrl #(
    .IN_MAX   (IN_MAX),
    .OUT_MAX  (OUT_MAX),
    .COLS_MAX (COLS_MAX),
    .M_W      (M_W),
    .R_W      (R_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mode   (in_ch.mode),
    .in_row    (in_ch.row_index),
    .in_col    (in_ch.col_index),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .row       (row),
    .m_idx     (m_idx),
    .status    (status)
  );

  fclf_dp #(
    .IN_MAX     (IN_MAX),
    .OUT_MAX    (OUT_MAX),
    .COLS_MAX   (COLS_MAX),
    .VALUE_BITS (VALUE_BITS),
    .M_W        (M_W),
    .R_W        (R_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .row       (row),
    .m_idx     (m_idx),
    .in_row    (in_ch.row_index),
    .in_col    (in_ch.col_index),
    .in_sample (in_ch.sample_value),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_dot   (out_ch.dot_value),
    .out_last  (out_ch.last)
  );

  `FCLF_ASSERT_SAME(a_no_req_during_mac, cmd.issue, !in_ch.ready, "request taken during a run")
  `FCLF_ASSERT_SAME(a_push_needs_room, cmd.push, status.out_free, "result overwrote a held result")
  `FCLF_ASSERT_SAME(a_done_after_issue, status.acc_done, !cmd.issue, "row finished while still reading")
  `FCLF_ASSERT_NEXT(a_last_row_shown, cmd.push && cmd.last_row, out_ch.valid && out_ch.last, "final row lost its last flag")

endmodule

`default_nettype wire

// ===== tb/fclf_forward_checker.sv =====
// Checker for the fully connected layer: predicts the rows of every column run and compares them.
`timescale 1ns / 1ps

module fclf_forward_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  fclf_in_if                              in_ch,
  fclf_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [fclf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fclf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              rows_pending,
  output int                              rows_checked
);
  import fclf_pkg::*;

  localparam int ROWS_MAX = 64;
  localparam int INS_MAX  = 256;
  localparam int COLS_MAX = 4;

  localparam longint ACC_HI = longint'(ACC_MAX);
  localparam longint ACC_LO = longint'(ACC_MIN);

  typedef struct packed {
    logic [OUT_ROW_W-1:0]    row;
    logic [OUT_COL_W-1:0]    col;
    logic signed [ACC_W-1:0] dot;
    logic                    last;
  } dot_row_t;

  logic signed [SAMPLE_W-1:0] weights [ROWS_MAX][INS_MAX];
  logic signed [SAMPLE_W-1:0] acts [INS_MAX][COLS_MAX];
  logic [IN_CNT_W-1:0]        n_inputs;
  logic [OUT_CNT_W-1:0]       n_outputs;
  dot_row_t                   dot_rows_due [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // One dot product per output row, saturated after every addition.
  task automatic predict_column(input int col);
    int       n_in;
    int       n_out;
    longint   acc;
    dot_row_t r;
    n_in  = (n_inputs == 0) ? 1 : (n_inputs > INS_MAX) ? INS_MAX : int'(n_inputs);
    n_out = (n_outputs == 0) ? 1 : (n_outputs > ROWS_MAX) ? ROWS_MAX : int'(n_outputs);
    for (int i = 0; i < n_out; i++) begin
      acc = 0;
      for (int m = 0; m < n_in; m++) begin
        acc += longint'(weights[i][m]) * longint'(acts[m][col]);
        if (acc > ACC_HI) begin
          acc = ACC_HI;
        end else if (acc < ACC_LO) begin
          acc = ACC_LO;
        end
      end
      r.row  = OUT_ROW_W'(i);
      r.col  = OUT_COL_W'(col);
      r.dot  = acc[ACC_W-1:0];
      r.last = (i == n_out - 1);
      dot_rows_due.push_back(r);
    end
  endtask

  task automatic take_request(input logic [MODE_W-1:0] mode, input int row, input int col,
                              input logic signed [SAMPLE_W-1:0] value);
    case (mode)
      MODE_LOAD_WEIGHT: begin
        if (row < ROWS_MAX && col < INS_MAX) weights[row][col] = value;
      end
      MODE_LOAD_INPUT: begin
        if (row < INS_MAX && col < COLS_MAX) acts[row][col] = value;
      end
      MODE_RUN: begin
        if (col < COLS_MAX) predict_column(col);
      end
      default: ;
    endcase
  endtask

  task automatic check_row(input dot_row_t got);
    dot_row_t want;
    if (dot_rows_due.size() == 0) begin
      report_mismatch($sformatf("row %0d of column %0d arrived with nothing outstanding",
                                got.row, got.col));
      return;
    end
    want = dot_rows_due.pop_front();
    rows_checked++;
    if (got.row != want.row)
      report_mismatch($sformatf("out_row got %0d, expected %0d", got.row, want.row));
    if (got.col != want.col)
      report_mismatch($sformatf("out_col got %0d, expected %0d", got.col, want.col));
    if (got.dot != want.dot)
      report_mismatch($sformatf("dot_value of row %0d got %0d, expected %0d",
                                want.row, got.dot, want.dot));
    if (got.last != want.last)
      report_mismatch($sformatf("last of row %0d got %0b, expected %0b",
                                want.row, got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_inputs     = IN_CNT_RESET;
      n_outputs    = OUT_CNT_RESET;
      fail_count   = 0;
      rows_checked = 0;
      dot_rows_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INPUT_COUNT:  n_inputs  = cfg_wdata[IN_CNT_W-1:0];
          CFG_OUTPUT_COUNT: n_outputs = cfg_wdata[OUT_CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        take_request(in_ch.mode, int'(in_ch.row_index), int'(in_ch.col_index),
                     in_ch.sample_value);
      if (out_ch.valid && out_ch.ready)
        check_row({out_ch.out_row, out_ch.out_col, out_ch.dot_value, out_ch.last});
    end
    rows_pending <= dot_rows_due.size();
  end

endmodule

// ===== tb/fully_connected_layer_forward_tb.sv =====
// Top of the fully connected layer testbench: clock, reset, requests, count settings and verdict.
`timescale 1ns / 1ps

module fully_connected_layer_forward_tb;
  import fclf_pkg::*;

  localparam int ROWS_MAX     = 64;
  localparam int INS_MAX      = 256;
  localparam int COLS_MAX     = 4;
  localparam int MAX_GAP      = 17;
  localparam int RANDOM_ITEMS = 140;
  // A dropped request may still be in flight when the last row returns; a full row is longer.
  localparam int SETTLE_CYCLES = INS_MAX + 16;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    rows_pending;
  int                    rows_checked;

  fclf_in_if  in_if ();
  fclf_out_if out_if ();

  // Store entries already written, so that a run never reads an unwritten one.
  bit w_loaded [ROWS_MAX][INS_MAX];
  bit x_loaded [INS_MAX][COLS_MAX];
  int n_in_eff      = INS_MAX;
  int n_out_eff     = ROWS_MAX;
  int in_calm_left  = 0;
  int out_calm_left = 0;
  int useful_sent   = 0;
  int runs_sent     = 0;
  int settings_used = 0;

  fully_connected_layer_forward u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  fclf_forward_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_if),
    .out_ch       (out_if),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .rows_pending (rows_pending),
    .rows_checked (rows_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Run did not finish in time.");
    $display("tb: failure");
    $finish;
  end

  // Occasional stretches with no idling at all, otherwise a random wait per request or result.
  function automatic int draw_gap(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic [MODE_W-1:0] mode, input int row, input int col,
                              input logic signed [SAMPLE_W-1:0] value);
    int gap;
    gap = draw_gap(in_calm_left);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= mode;
    in_if.row_index    <= INDEX_W'(row);
    in_if.col_index    <= INDEX_W'(col);
    in_if.sample_value <= value;
    do @(posedge clk); while (!in_if.ready);
    if (mode == MODE_LOAD_WEIGHT && row < ROWS_MAX && col < INS_MAX) begin
      w_loaded[row][col] = 1'b1;
      useful_sent++;
    end else if (mode == MODE_LOAD_INPUT && row < INS_MAX && col < COLS_MAX) begin
      x_loaded[row][col] = 1'b1;
      useful_sent++;
    end else if (mode == MODE_RUN && col < COLS_MAX) begin
      runs_sent++;
      useful_sent++;
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_counts(input int n_in, input int n_out);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INPUT_COUNT;
    cfg_wdata <= CFG_DATA_W'(n_in);
    @(posedge clk);
    cfg_index <= CFG_OUTPUT_COUNT;
    cfg_wdata <= CFG_DATA_W'(n_out);
    @(posedge clk);
    cfg_we    <= 1'b0;
    // The block clamps both counts to its store sizes.
    n_in_eff  = (n_in == 0) ? 1 : (n_in > INS_MAX) ? INS_MAX : n_in;
    n_out_eff = (n_out % 128 == 0) ? 1 : (n_out % 128 > ROWS_MAX) ? ROWS_MAX : n_out % 128;
    settings_used++;
  endtask

  // Fills whatever the run is about to read, then requests the run itself.
  task automatic run_column(input int col);
    for (int i = 0; i < n_out_eff; i++)
      for (int m = 0; m < n_in_eff; m++)
        if (!w_loaded[i][m]) send_request(MODE_LOAD_WEIGHT, i, m, draw_value());
    for (int m = 0; m < n_in_eff; m++)
      if (!x_loaded[m][col]) send_request(MODE_LOAD_INPUT, m, col, draw_value());
    send_request(MODE_RUN, $urandom_range(0, 255), col, SAMPLE_W'($urandom));
  endtask

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_request(MODE_LOAD_WEIGHT, $urandom_range(0, n_out_eff - 1),
                   $urandom_range(0, n_in_eff - 1), draw_value());
    end else if (pick < 45) begin
      send_request(MODE_LOAD_WEIGHT, $urandom_range(0, ROWS_MAX - 1),
                   $urandom_range(0, INS_MAX - 1), draw_value());
    end else if (pick < 70) begin
      send_request(MODE_LOAD_INPUT, $urandom_range(0, n_in_eff - 1),
                   $urandom_range(0, COLS_MAX - 1), draw_value());
    end else if (pick < 90) begin
      run_column($urandom_range(0, COLS_MAX - 1));
    end else begin
      case ($urandom_range(0, 3))
        0: send_request(MODE_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                        draw_value());
        1: send_request(MODE_LOAD_WEIGHT, $urandom_range(ROWS_MAX, 255),
                        $urandom_range(0, 255), draw_value());
        2: send_request(MODE_LOAD_INPUT, $urandom_range(0, 255),
                        $urandom_range(COLS_MAX, 255), draw_value());
        default: send_request(MODE_RUN, $urandom_range(0, 255),
                              $urandom_range(COLS_MAX, 255), draw_value());
      endcase
    end
  endtask

  // Result side: a random stall before each result, with calm stretches.
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_gap(out_calm_left);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  initial begin
    int start_count;
    int n;
    int k;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_INPUT_COUNT;
    cfg_wdata          <= '0;
    in_if.valid        <= 1'b0;
    in_if.mode         <= MODE_LOAD_WEIGHT;
    in_if.row_index    <= '0;
    in_if.col_index    <= '0;
    in_if.sample_value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: the largest products, dropped requests and every operation.
    set_counts(2, 2);
    send_request(MODE_LOAD_WEIGHT, 0, 0, 16'sh7FFF);
    send_request(MODE_LOAD_WEIGHT, 0, 1, 16'sh8000);
    send_request(MODE_LOAD_WEIGHT, 1, 0, 16'sh8000);
    send_request(MODE_LOAD_WEIGHT, 1, 1, 16'sh8000);
    send_request(MODE_LOAD_INPUT, 0, 3, 16'sh8000);
    send_request(MODE_LOAD_INPUT, 1, 3, 16'sh8000);
    send_request(MODE_RUN, 0, 3, 16'sh0000);
    send_request(MODE_UNUSED, 255, 255, 16'shFFFF);
    send_request(MODE_LOAD_WEIGHT, ROWS_MAX, 0, 16'sh1234);
    send_request(MODE_LOAD_WEIGHT, 255, 255, 16'shFFFF);
    send_request(MODE_LOAD_WEIGHT, 0, 255, 16'shFFFF);
    send_request(MODE_LOAD_INPUT, 255, 3, 16'sh7FFF);
    send_request(MODE_LOAD_INPUT, 0, COLS_MAX, 16'sh5A5A);
    send_request(MODE_LOAD_INPUT, 0, 255, 16'shA5A5);
    send_request(MODE_RUN, 0, COLS_MAX, 16'sh0000);
    send_request(MODE_RUN, 255, 255, 16'shFFFF);
    send_request(MODE_LOAD_INPUT, 0, 0, 16'sh0000);
    send_request(MODE_LOAD_INPUT, 1, 0, 16'sh0001);
    // Row index and value mean nothing on a run.
    send_request(MODE_RUN, 255, 0, 16'sh7FFF);

    // Count extremes, including values that the block has to clamp.
    set_counts(0, 127);
    run_column(1);
    set_counts(1, 64);
    run_column(2);
    set_counts(2, 0);
    run_column(0);

    // Random phases: a new count setting, random requests, then a closing run.
    start_count = useful_sent;
    while (useful_sent - start_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(0, 4);
          k = $urandom_range(0, 1);
        end
        1: begin
          n = $urandom_range(0, 2);
          k = ($urandom_range(0, 1) != 0) ? ROWS_MAX : $urandom_range(ROWS_MAX + 1, 127);
        end
        2, 3: begin
          n = $urandom_range(13, 24);
          k = $urandom_range(1, 4);
        end
        default: begin
          n = $urandom_range(1, 12);
          k = $urandom_range(1, 8);
        end
      endcase
      set_counts(n, k);
      repeat ($urandom_range(4, 16)) begin
        random_request();
        if ($urandom_range(0, 24) == 0) wait_idle();
      end
      run_column($urandom_range(0, COLS_MAX - 1));
    end

    wait_idle();
    $display("Covered %0d accepted requests with %0d column runs over %0d count settings;",
             useful_sent, runs_sent, settings_used);
    $display("%0d result rows were compared against the prediction.", rows_checked);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fclf_pkg.sv
sv/fclf_if.sv
sv/fclf_ctrl.sv
sv/fclf_dp.sv
sv/fully_connected_layer_forward.sv
tb/fclf_forward_checker.sv
tb/fully_connected_layer_forward_tb.sv
